### hw/rtl/ert_pkg.sv
// Shared types and constants of the entity reference tokenizer.
package ert_pkg;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_DOT  = 8'h2E;

    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int MAX_TOKS  = 3;

    typedef enum logic [2:0] {
        KIND_LIT   = 3'd0,
        KIND_START = 3'd1,
        KIND_NAME  = 3'd2,
        KIND_PART  = 3'd3,
        KIND_SEP   = 3'd4,
        KIND_END   = 3'd5,
        KIND_ERR   = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_DOT      = 2'd1,
        ERR_TOO_LONG = 2'd2,
        ERR_OPEN_END = 2'd3
    } t_err;

    typedef enum logic [1:0] {
        MODE_OUT    = 2'd0,
        MODE_IN     = 2'd1,
        MODE_ABSORB = 2'd2,
        MODE_ERR    = 2'd3
    } t_mode;

    typedef struct packed {
        t_err        code;
        logic [7:0]  data;
        t_kind       kind;
    } t_token;

    typedef struct packed {
        logic [1:0]  count;
        t_token [MAX_TOKS-1:0] tok;
    } t_bundle;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

### hw/rtl/ert_front.sv
// Front part: accepts text bytes, runs the parser state and forms token bundles.
module ert_front #(
    parameter int MAX_ENTITY_LEN = 128
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_resolve_enable,
    input  logic             i_valid,
    input  logic [7:0]       i_data,
    input  logic             i_eob,
    output logic             o_ready,
    input  ert_pkg::t_q_status i_q_status,
    output logic             o_push,
    output ert_pkg::t_bundle o_bundle
);
    import ert_pkg::*;

    localparam logic [7:0] MAX_LEN = 8'(MAX_ENTITY_LEN);

    t_mode      r_mode, n_mode;
    logic       r_pend, n_pend;
    logic [7:0] r_len, n_len;
    logic       r_name, n_name;
    logic       r_parts, n_parts;
    logic       w_accept;

    function automatic t_bundle add_tok(t_bundle bd, t_kind k, logic [7:0] b, t_err e);
        t_bundle r;
        r = bd;
        if (bd.count != 2'd3) begin
            r.tok[bd.count].kind = k;
            r.tok[bd.count].data = b;
            r.tok[bd.count].code = e;
            r.count = bd.count + 2'd1;
        end
        return r;
    endfunction

    function automatic logic [7:0] grow(logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    assign o_ready  = !i_q_status.full;
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_OUT;
            r_pend  <= 1'b0;
            r_len   <= 8'd0;
            r_name  <= 1'b0;
            r_parts <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_pend  <= n_pend;
            r_len   <= n_len;
            r_name  <= n_name;
            r_parts <= n_parts;
        end
    end

    always_comb begin
        t_mode      m;
        logic       pa;
        logic [7:0] len;
        logic       ns;
        logic       ps;
        logic       do_handle;
        t_bundle    bd;
        m         = r_mode;
        pa        = r_pend;
        len       = r_len;
        ns        = r_name;
        ps        = r_parts;
        do_handle = 1'b1;
        bd        = '0;
        if (w_accept) begin
            if (pa) begin
                pa = 1'b0;
                if (i_data == CH_AMP) begin
                    bd = add_tok(bd, KIND_LIT, CH_AMP, ERR_NONE);
                    do_handle = 1'b0;
                end else if (i_resolve_enable) begin
                    bd  = add_tok(bd, KIND_START, 8'd0, ERR_NONE);
                    m   = MODE_IN;
                    len = 8'd0;
                    ns  = 1'b0;
                    ps  = 1'b0;
                end else begin
                    bd = add_tok(bd, KIND_LIT, CH_AMP, ERR_NONE);
                end
            end
            if (do_handle) begin
                priority if (m == MODE_ERR) begin
                    bd = bd;
                end else if (m == MODE_ABSORB) begin
                    bd  = add_tok(bd, KIND_PART, i_data, ERR_NONE);
                    len = grow(len);
                    ps  = 1'b1;
                    m   = MODE_IN;
                end else if (i_data == CH_AMP) begin
                    if (!i_eob) begin
                        pa = 1'b1;
                    end else if (i_resolve_enable) begin
                        bd  = add_tok(bd, KIND_START, 8'd0, ERR_NONE);
                        m   = MODE_IN;
                        len = 8'd0;
                        ns  = 1'b0;
                        ps  = 1'b0;
                    end else begin
                        bd = add_tok(bd, KIND_LIT, CH_AMP, ERR_NONE);
                    end
                end else if (!(i_resolve_enable && m == MODE_IN)) begin
                    bd = add_tok(bd, KIND_LIT, i_data, ERR_NONE);
                end else if (i_data == CH_SEMI) begin
                    bd = add_tok(bd, KIND_END, 8'd0, ERR_NONE);
                    m  = MODE_OUT;
                end else if (i_data == CH_DOT) begin
                    if (!ns) begin
                        bd = add_tok(bd, KIND_ERR, 8'd0, ERR_DOT);
                        m  = MODE_ERR;
                    end else begin
                        len = grow(len);
                        if (ps) begin
                            bd = add_tok(bd, KIND_SEP, 8'd0, ERR_NONE);
                        end else begin
                            m = MODE_ABSORB;
                        end
                    end
                end else if (len >= MAX_LEN) begin
                    bd = add_tok(bd, KIND_ERR, 8'd0, ERR_TOO_LONG);
                    m  = MODE_ERR;
                end else begin
                    len = grow(len);
                    if (ps) begin
                        bd = add_tok(bd, KIND_PART, i_data, ERR_NONE);
                    end else begin
                        bd = add_tok(bd, KIND_NAME, i_data, ERR_NONE);
                        ns = 1'b1;
                    end
                end
            end
            if (i_eob) begin
                if (m == MODE_IN || m == MODE_ABSORB) begin
                    bd = add_tok(bd, KIND_ERR, 8'd0, ERR_OPEN_END);
                end
                m   = MODE_OUT;
                pa  = 1'b0;
                len = 8'd0;
                ns  = 1'b0;
                ps  = 1'b0;
            end
        end
        n_mode   = m;
        n_pend   = pa;
        n_len    = len;
        n_name   = ns;
        n_parts  = ps;
        o_bundle = bd;
        o_push   = w_accept && (bd.count != 2'd0);
    end

endmodule

### hw/rtl/ert_queue.sv
// Short queue of token bundles between the front and back parts.
module ert_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ert_pkg::t_bundle   i_bundle,
    input  logic               i_pop,
    output ert_pkg::t_bundle   o_head,
    output ert_pkg::t_q_status o_status
);
    import ert_pkg::*;

    t_bundle              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr, r_rd;
    logic [Q_PTR_W:0]     r_cnt;
    logic                 w_do_push, w_do_pop;

    assign o_status.full  = (r_cnt == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign w_do_push      = i_push && !o_status.full;
    assign w_do_pop       = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/ert_back.sv
// Back part: takes bundles from the queue and sends their tokens one beat at a time.
module ert_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ert_pkg::t_bundle   i_head,
    input  ert_pkg::t_q_status i_q_status,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output ert_pkg::t_token    o_token,
    output logic               o_last
);
    import ert_pkg::*;

    t_bundle    r_bundle;
    logic [1:0] r_idx;
    logic       r_busy;
    logic       w_done;

    assign o_valid = r_busy;
    assign o_token = r_bundle.tok[r_idx];
    assign o_last  = (r_idx == r_bundle.count - 2'd1);
    assign w_done  = r_busy && i_ready && o_last;
    assign o_pop   = (!r_busy || w_done) && !i_q_status.empty;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bundle <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (w_done) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (r_busy && i_ready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule

### hw/rtl/entity_reference_tokenizer_unit.sv
// Top level of the entity reference tokenizer.
//
// Text bytes enter on the s_axis channel, one beat per byte, with tlast on the
// final byte of a buffer. Tokens leave on the m_axis channel, one beat per token,
// with the token kind on tuser and tlast on the last token caused by a given byte.
// A byte may cause zero to three tokens. The cfg channel writes resolve_enable and
// is always ready; it must be written only while the block is idle, which the block
// itself does not enforce. Once the back part loads a byte's bundle, its first
// token shows. Input is taken one byte per cycle while the bundle queue has room;
// output runs at one token per cycle while the receiver is ready, so bytes that
// cause several tokens set the sustained rate through the single output port.
// Reset clears the parser, the queue and the output, and sets resolve_enable.
// When the receiver stalls, the current token holds and the queue fills; once it
// holds four bundles, s_axis tready drops until a bundle is taken.
module entity_reference_tokenizer_unit #(
    parameter int MAX_ENTITY_LEN = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // data_byte
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // token_byte[7:0], error_code[9:8]
    output logic [2:0]  o_m_axis_tuser,   // token_kind[2:0]
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);
    import ert_pkg::*;

    logic      r_resolve_enable;
    logic      w_push, w_pop;
    t_bundle   w_bundle, w_head;
    t_q_status w_q_status;
    t_token    w_token;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resolve_enable <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_resolve_enable <= i_cfg_data;
        end
    end

    ert_front #(
        .MAX_ENTITY_LEN(MAX_ENTITY_LEN)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_resolve_enable(r_resolve_enable),
        .i_valid         (i_s_axis_tvalid),
        .i_data          (i_s_axis_tdata),
        .i_eob           (i_s_axis_tlast),
        .o_ready         (o_s_axis_tready),
        .i_q_status      (w_q_status),
        .o_push          (w_push),
        .o_bundle        (w_bundle)
    );

    ert_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_bundle(w_bundle),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_status(w_q_status)
    );

    ert_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (w_head),
        .i_q_status(w_q_status),
        .o_pop     (w_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_token   (w_token),
        .o_last    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {6'b000000, w_token.code, w_token.data};
    assign o_m_axis_tuser = w_token.kind;

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("Output beat shown right after reset.");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == KIND_ERR) |-> o_m_axis_tdata[9:8] != ERR_NONE)
        else $error("Error token without an error code.");

    a_no_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != KIND_ERR) |-> o_m_axis_tdata[9:8] == ERR_NONE)
        else $error("Error code on a token that is not an error.");

    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == KIND_START || o_m_axis_tuser == KIND_SEP
         || o_m_axis_tuser == KIND_END || o_m_axis_tuser == KIND_ERR))
        |-> o_m_axis_tdata[7:0] == 8'd0)
        else $error("Byte value on a token kind that carries none.");

endmodule

### verif/tb_entity_reference_tokenizer_unit.sv
// Self-checking testbench for the entity reference tokenizer against a token predictor.
`timescale 1ns / 1ps

module tb_entity_reference_tokenizer_unit;

    import ert_pkg::*;

    localparam int ENTITY_LIMIT = 128;
    localparam int IDLE_LIMIT   = 2000;
    localparam int LONG_HOLD    = 300;

    typedef struct {
        t_kind      kind;
        logic [7:0] data;
        t_err       code;
        logic       last_tok;
    } t_token_exp;

    typedef struct {
        logic [7:0] value;
        logic       eob;
    } t_text_beat;

    class token_scoreboard;
        logic       resolve_en;
        t_mode      mode;
        bit         amp_held;
        logic [7:0] ent_len;
        bit         name_seen;
        bit         parts_started;
        t_token_exp step_q[$];
        t_token_exp expected_q[$];
        int         mismatches;
        int         tokens_checked;
        int         bytes_noted;
        int         kind_seen[0:6];

        function new();
            resolve_en = 1'b1;
            clear_parse();
        endfunction

        function void clear_parse();
            mode          = MODE_OUT;
            amp_held      = 0;
            ent_len       = 8'd0;
            name_seen     = 0;
            parts_started = 0;
        endfunction

        function void set_resolve(logic en);
            resolve_en = en;
        endfunction

        function void push_tok(t_kind kind, logic [7:0] data, t_err code);
            t_token_exp t;
            if (step_q.size() >= MAX_TOKS)
                return;
            t.kind     = kind;
            t.data     = data;
            t.code     = code;
            t.last_tok = 1'b0;
            step_q.push_back(t);
        endfunction

        function void bump_length();
            if (ent_len != 8'hFF)
                ent_len++;
        endfunction

        function void open_or_literal_amp();
            if (resolve_en) begin
                push_tok(KIND_START, 8'd0, ERR_NONE);
                mode          = MODE_IN;
                ent_len       = 8'd0;
                name_seen     = 0;
                parts_started = 0;
            end else begin
                push_tok(KIND_LIT, CH_AMP, ERR_NONE);
            end
        endfunction

        function void parse_byte(logic [7:0] b, logic eob);
            bit active;
            active = resolve_en && mode == MODE_IN;
            if (mode == MODE_ERR)
                return;
            if (mode == MODE_ABSORB) begin
                push_tok(KIND_PART, b, ERR_NONE);
                bump_length();
                parts_started = 1;
                mode = MODE_IN;
                return;
            end
            if (b == CH_AMP) begin
                if (eob)
                    open_or_literal_amp();
                else
                    amp_held = 1;
                return;
            end
            if (!active) begin
                push_tok(KIND_LIT, b, ERR_NONE);
                return;
            end
            if (b == CH_SEMI) begin
                push_tok(KIND_END, 8'd0, ERR_NONE);
                mode = MODE_OUT;
            end else if (b == CH_DOT) begin
                if (!name_seen) begin
                    push_tok(KIND_ERR, 8'd0, ERR_DOT);
                    mode = MODE_ERR;
                    return;
                end
                bump_length();
                if (parts_started)
                    push_tok(KIND_SEP, 8'd0, ERR_NONE);
                else
                    mode = MODE_ABSORB;
            end else begin
                if (ent_len >= ENTITY_LIMIT) begin
                    push_tok(KIND_ERR, 8'd0, ERR_TOO_LONG);
                    mode = MODE_ERR;
                    return;
                end
                bump_length();
                if (parts_started) begin
                    push_tok(KIND_PART, b, ERR_NONE);
                end else begin
                    push_tok(KIND_NAME, b, ERR_NONE);
                    name_seen = 1;
                end
            end
        endfunction

        function void note_byte(logic [7:0] b, logic eob);
            step_q.delete();
            if (amp_held) begin
                amp_held = 0;
                if (b == CH_AMP) begin
                    push_tok(KIND_LIT, CH_AMP, ERR_NONE);
                end else begin
                    open_or_literal_amp();
                    parse_byte(b, eob);
                end
            end else begin
                parse_byte(b, eob);
            end
            if (eob) begin
                if (mode == MODE_IN || mode == MODE_ABSORB)
                    push_tok(KIND_ERR, 8'd0, ERR_OPEN_END);
                clear_parse();
            end
            if (step_q.size() > 0)
                step_q[step_q.size() - 1].last_tok = 1'b1;
            foreach (step_q[i])
                expected_q.push_back(step_q[i]);
            bytes_noted++;
        endfunction

        function void check_token(logic [2:0] tuser, logic [15:0] tdata, logic tlast);
            t_token_exp exp;
            if (expected_q.size() == 0) begin
                $error("unexpected token beat: tuser=%h tdata=%h tlast=%b", tuser, tdata, tlast);
                mismatches++;
                return;
            end
            exp = expected_q.pop_front();
            tokens_checked++;
            kind_seen[exp.kind]++;
            if (tuser !== exp.kind) begin
                $error("token_kind: expected %0d, actual %0d", exp.kind, tuser);
                mismatches++;
            end
            if (tdata[7:0] !== exp.data) begin
                $error("token_byte: expected %h, actual %h", exp.data, tdata[7:0]);
                mismatches++;
            end
            if (tdata[9:8] !== exp.code) begin
                $error("error_code: expected %0d, actual %0d", exp.code, tdata[9:8]);
                mismatches++;
            end
            if (tdata[15:10] !== 6'b000000) begin
                $error("tdata padding: expected 0, actual %b", tdata[15:10]);
                mismatches++;
            end
            if (tlast !== exp.last_tok) begin
                $error("last_token: expected %b, actual %b", exp.last_tok, tlast);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = 8'd0;
    logic        s_tlast   = 1'b0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_data  = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [15:0] o_m_axis_tdata;   // token_byte[7:0], error_code[9:8]
    logic [2:0]  o_m_axis_tuser;   // token_kind[2:0]
    logic        o_m_axis_tlast;
    logic        o_cfg_ready;

    token_scoreboard sb;
    t_text_beat      text_q[$];
    int              burst_left;
    int              idle_cycles;
    int              pattern_sel;
    int              pattern_left;
    int              hold_left;
    bit              hold_done;

    entity_reference_tokenizer_unit #(
        .MAX_ENTITY_LEN(ENTITY_LIMIT)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [7:0] random_plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CH_AMP || b == CH_SEMI || b == CH_DOT)
            b = 8'h61;
        return b;
    endfunction

    function automatic void add_byte(logic [7:0] b, logic eob);
        t_text_beat beat;
        beat.value = b;
        beat.eob   = eob;
        text_q.push_back(beat);
    endfunction

    function automatic void add_text(string s, logic eob);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i], eob && (i == s.len() - 1));
    endfunction

    task automatic write_resolve(input logic en);
        cfg_valid <= 1'b1;
        cfg_data  <= en;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        sb.set_resolve(en);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_text();
        t_text_beat beat;
        while (text_q.size() > 0) begin
            beat = text_q.pop_front();
            if (burst_left == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8))
                    @(posedge i_clk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(1, 12);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= beat.value;
            s_tlast  <= beat.eob;
            @(posedge i_clk);
            while (!o_s_axis_tready)
                @(posedge i_clk);
            sb.note_byte(beat.value, beat.eob);
            burst_left--;
        end
        s_tvalid   <= 1'b0;
        burst_left = 0;
    endtask

    task automatic run_phase(input int n_items, input bit with_extremes, input string tail);
        logic [7:0] seg[$];
        int         target;
        int         kind_sel;
        int         cut;
        if (with_extremes) begin
            add_byte(random_plain_byte(), 1'b1);
            // The length limit is crossed inside a part, then the counter saturates.
            add_byte(CH_AMP, 1'b0);
            repeat (100)
                add_byte(random_plain_byte(), 1'b0);
            add_text(".x", 1'b0);
            repeat (26)
                add_byte(random_plain_byte(), 1'b0);
            add_text("yz;", 1'b1);
            add_text("&a.b", 1'b0);
            repeat (256)
                add_byte(CH_DOT, 1'b0);
            add_text("c;", 1'b1);
        end
        target = text_q.size() + n_items;
        while (text_q.size() < target) begin
            repeat ($urandom_range(1, 5)) begin
                seg.delete();
                kind_sel = $urandom_range(0, 9);
                if (kind_sel <= 6) begin
                    seg.push_back(CH_AMP);
                    repeat ($urandom_range(1, 6))
                        seg.push_back(random_plain_byte());
                    repeat ($urandom_range(0, 3)) begin
                        seg.push_back(CH_DOT);
                        seg.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                                  : random_plain_byte());
                        repeat ($urandom_range(0, 3))
                            seg.push_back(random_plain_byte());
                    end
                    seg.push_back(CH_SEMI);
                    if (kind_sel == 6) begin
                        if ($urandom_range(0, 1)) begin
                            seg.insert(1, CH_DOT);
                        end else begin
                            cut = $urandom_range(1, seg.size() - 1);
                            while (seg.size() > cut)
                                void'(seg.pop_back());
                        end
                    end
                end else if (kind_sel == 7) begin
                    seg.push_back(CH_AMP);
                    seg.push_back(CH_AMP);
                end else begin
                    repeat ($urandom_range(1, 6))
                        seg.push_back((kind_sel == 9) ? 8'($urandom_range(0, 255))
                                                      : random_plain_byte());
                end
                foreach (seg[i])
                    add_byte(seg[i], 1'b0);
            end
            text_q[text_q.size() - 1].eob = 1'b1;
        end
        add_text(tail, 1'b0);
        send_text();
        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (8)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (rst_n && o_m_axis_tvalid && m_tready)
            sb.check_token(o_m_axis_tuser, o_m_axis_tdata, o_m_axis_tlast);
        if (rst_n && !hold_done && sb.bytes_noted >= 250) begin
            hold_left = LONG_HOLD;
            hold_done = 1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                pattern_sel  = $urandom_range(0, 3);
                pattern_left = $urandom_range(20, 200);
            end
            pattern_left--;
            case (pattern_sel)
                0: begin
                    m_tready <= 1'b1;
                end
                1: begin
                    m_tready <= ($urandom_range(0, 3) != 0);
                end
                2: begin
                    m_tready <= $urandom_range(0, 1);
                end
                default: begin
                    m_tready <= ($urandom_range(0, 4) == 0);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (!rst_n || (s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready)
                || (cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no beat accepted for %0d cycles.", IDLE_LIMIT);
                $display("tb_entity_reference_tokenizer_unit failed");
                $finish;
            end
        end
    end

    initial begin
        sb = new();
        repeat (10)
            @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        write_resolve(1'b1);

        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b1);
        add_text("&&", 1'b0);
        add_text("&a.b.c;", 1'b0);
        add_text("&.zx", 1'b1);
        add_text("&q&&&r.", 1'b1);
        add_text("&", 1'b1);
        run_phase(30, 1'b0, "&ab.");

        write_resolve(1'b0);
        run_phase(25, 1'b0, "&");

        write_resolve(1'b1);
        run_phase(15, 1'b1, "");

        if (sb.expected_q.size() != 0) begin
            $error("%0d expected tokens never arrived", sb.expected_q.size());
            sb.mismatches++;
        end
        $display("Covered %0d text bytes and %0d tokens with the resolver on, off and on again.",
                 sb.bytes_noted, sb.tokens_checked);
        $display("Seen %0d entity ends and %0d error tokens, with length overflow and saturation.",
                 sb.kind_seen[KIND_END], sb.kind_seen[KIND_ERR]);
        if (sb.mismatches == 0)
            $display("tb_entity_reference_tokenizer_unit passed");
        else
            $display("tb_entity_reference_tokenizer_unit failed");
        $finish;
    end

endmodule
